// File: rtl/core/ars_pkg.sv
// ----------------------------------------------------------------------------
// ars_pkg
// Shared types and constants for the ack/retry spool.
// ----------------------------------------------------------------------------
package ars_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = 5;

  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_ACK  = 2'd2,
    OP_TICK = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_OVERFLOW  = 3'd1,
    ST_UNDERFLOW = 3'd2,
    ST_ACK_MATCH = 3'd3,
    ST_ACK_MISS  = 3'd4,
    ST_ACK_IGN   = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    E_FREE  = 2'd0,
    E_READY = 2'd1,
    E_WAIT  = 2'd2
  } estat_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH,
    S_OUT
  } fsm_t;

  localparam logic [0:0] CFG_TIMEOUT = 1'b0;
  localparam logic [0:0] CFG_RETRY   = 1'b1;

  // Controller -> datapath
  typedef struct packed {
    logic load;     // latch the input word, clear scan state
    logic scan;     // visit entry at scan index
    logic finish;   // apply the decision of the scan
  } ars_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic last;     // scan index is at the final entry
    logic found;    // early exit condition hit
  } ars_stat_t;

  // Result word, highest bits first: status lands in the lowest bits
  typedef struct packed {
    logic [15:0] failed_total;
    logic [4:0]  waiting_count;
    logic [4:0]  ready_count;
    logic [4:0]  used_count;
    logic        evicted;
    logic [7:0]  out_priority;
    logic        out_token_flag;
    logic [14:0] out_token;
    logic [15:0] out_handle;
    logic [2:0]  status;
  } ars_res_t;

endpackage

// File: rtl/core/ars_ctrl.sv
// ----------------------------------------------------------------------------
// ars_ctrl
// Sequencer: load, scan the table one entry a cycle, finish, present result.
// ----------------------------------------------------------------------------
module ars_ctrl import ars_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_fire,
  input  logic      out_free,
  input  ars_stat_t stat,
  output ars_cmd_t  cmd,
  output logic      busy,
  output logic      res_load
);

  fsm_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    res_load   = 1'b0;
    busy       = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          cmd.load   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.found || stat.last) state_next = S_FINISH;
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        // wait until the output register is empty or being drained this cycle
        if (out_free) begin
          res_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// File: rtl/core/ars_dp.sv
// ----------------------------------------------------------------------------
// ars_dp
// Entry table, scan state, counters and result assembly.
// ----------------------------------------------------------------------------
module ars_dp import ars_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  ars_cmd_t    cmd,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_idx,
  input  logic [15:0] cfg_data,
  input  logic [1:0]  operation,
  input  logic [15:0] packet_handle,
  input  logic [7:0]  priority_req,
  input  logic [14:0] token,
  input  logic        token_ack_flag,
  input  logic        wants_ack,
  input  logic [15:0] elapsed_ms,
  output ars_stat_t   stat,
  output ars_res_t    res
);

  logic [15:0] ack_timeout;
  logic [7:0]  retry_lim;

  estat_t      e_stat  [ENTRIES];
  logic [7:0]  e_prio  [ENTRIES];
  logic [7:0]  e_att   [ENTRIES];
  logic [17:0] e_time  [ENTRIES];
  logic [15:0] e_handle[ENTRIES];
  logic [15:0] e_token [ENTRIES];
  logic        e_wack  [ENTRIES];

  logic [CNT_W-1:0] used_t, ready_t, wait_t;
  logic [15:0]      failed;

  // latched input word
  op_t         op;
  logic [15:0] r_handle, r_elapsed;
  logic [7:0]  r_prio;
  logic [14:0] r_tok;
  logic        r_flag, r_wack;

  // scan state
  logic [IDX_W-1:0] idx;
  logic             hit;
  logic [IDX_W-1:0] hit_idx;
  logic [7:0]       low;
  logic             low_ok;
  logic [IDX_W-1:0] low_idx;

  logic [2:0]  r_status;
  logic [15:0] r_oh;
  logic [14:0] r_ot;
  logic        r_of, r_ev;
  logic [7:0]  r_op;

  logic        cur_free, cur_ready, cur_wmatch;
  logic [17:0] time_sub;
  logic        expired;

  always_comb begin
    cur_free   = (e_stat[idx] == E_FREE);
    cur_ready  = (e_stat[idx] == E_READY);
    cur_wmatch = (e_stat[idx] == E_WAIT) && (e_token[idx] == {1'b0, r_tok});
    time_sub   = e_time[idx] - {2'b00, r_elapsed};
    // signed 18-bit value at or below zero
    expired    = time_sub[17] || (time_sub == '0);
    stat.last  = (idx == IDX_W'(ENTRIES - 1));
    stat.found = 1'b0;
    unique case (op)
      OP_PUSH: stat.found = cur_free;
      OP_POP:  stat.found = cur_ready;
      OP_ACK:  stat.found = !r_flag || cur_wmatch;
      OP_TICK: stat.found = 1'b0;
      default: stat.found = 1'b0;
    endcase
  end

  // a retire of an entry in a given state
  function automatic logic [CNT_W-1:0] dec(input logic [CNT_W-1:0] v, input logic c);
    dec = (c && v != '0) ? v - 1'b1 : v;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      ack_timeout <= 16'd2500;
      retry_lim   <= 8'd5;
      used_t      <= '0;
      ready_t     <= '0;
      wait_t      <= '0;
      failed      <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        e_stat[i] <= E_FREE;
        e_prio[i] <= '0;
        e_att[i]  <= '0;
        e_time[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_TIMEOUT: ack_timeout <= cfg_data;
          CFG_RETRY:   retry_lim   <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (cmd.scan && op == OP_TICK && e_stat[idx] == E_WAIT) begin
        e_time[idx] <= time_sub;
        if (expired) begin
          if (e_att[idx] < retry_lim) begin
            e_stat[idx] <= E_READY;
            ready_t     <= ready_t + 1'b1;
            wait_t      <= dec(wait_t, 1'b1);
          end else begin
            e_stat[idx] <= E_FREE;
            wait_t      <= dec(wait_t, 1'b1);
            used_t      <= dec(used_t, 1'b1);
            failed      <= failed + 1'b1;
          end
        end
      end
      if (cmd.finish && hit) begin
        unique case (op)
          OP_PUSH: begin
            e_stat[hit_idx] <= E_READY;
            e_prio[hit_idx] <= r_prio;
            e_att[hit_idx]  <= '0;
            e_time[hit_idx] <= '0;
            if (r_ev) begin
              // evicted slot: retire it, then count the new one
              used_t  <= used_t;
              ready_t <= dec(ready_t, e_stat[hit_idx] == E_READY) + 1'b1;
              wait_t  <= dec(wait_t, e_stat[hit_idx] == E_WAIT);
            end else begin
              used_t  <= used_t + 1'b1;
              ready_t <= ready_t + 1'b1;
            end
          end
          OP_POP: begin
            if (e_wack[hit_idx] && !e_token[hit_idx][15]) begin
              e_stat[hit_idx] <= E_WAIT;
              e_time[hit_idx] <= {2'b00, ack_timeout};
              if (e_att[hit_idx] != 8'hFF) e_att[hit_idx] <= e_att[hit_idx] + 1'b1;
              wait_t  <= wait_t + 1'b1;
            end else begin
              e_stat[hit_idx] <= E_FREE;
              used_t  <= dec(used_t, 1'b1);
            end
            ready_t <= dec(ready_t, 1'b1);
          end
          OP_ACK: begin
            e_stat[hit_idx] <= E_FREE;
            wait_t <= dec(wait_t, 1'b1);
            used_t <= dec(used_t, 1'b1);
          end
          default: ;
        endcase
      end
    end
  end

  // payload fields, no reset
  always_ff @(posedge clk) begin
    if (cmd.finish && hit && op == OP_PUSH) begin
      e_handle[hit_idx] <= r_handle;
      e_token[hit_idx]  <= {r_flag, r_tok};
      e_wack[hit_idx]   <= r_wack;
    end
  end

  // scan registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op        <= op_t'(operation);
      r_handle  <= packet_handle;
      r_prio    <= priority_req;
      r_tok     <= token;
      r_flag    <= token_ack_flag;
      r_wack    <= wants_ack;
      r_elapsed <= elapsed_ms;
      idx       <= '0;
      hit       <= 1'b0;
      hit_idx   <= '0;
      low       <= priority_req;
      low_ok    <= 1'b0;
      low_idx   <= '0;
    end else if (cmd.scan) begin
      if (op == OP_PUSH && e_prio[idx] < low) begin
        low     <= e_prio[idx];
        low_ok  <= 1'b1;
        low_idx <= idx;
      end
      if (stat.found) begin
        hit     <= (op != OP_ACK) || r_flag;
        hit_idx <= idx;
      end else if (stat.last && op == OP_PUSH && low_ok) begin
        hit     <= 1'b1;
        hit_idx <= (e_prio[idx] < low) ? idx : low_idx;
      end else if (stat.last && op == OP_PUSH && e_prio[idx] < low) begin
        hit     <= 1'b1;
        hit_idx <= idx;
      end
      if (!stat.last) idx <= idx + 1'b1;
    end
  end

  // per-op result fields, fixed at the end of the scan
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      unique case (op)
        OP_PUSH: begin
          r_status <= hit ? ST_OK : ST_OVERFLOW;
          r_oh <= '0; r_ot <= '0; r_of <= 1'b0; r_op <= '0;
        end
        OP_POP: begin
          r_status <= hit ? ST_OK : ST_UNDERFLOW;
          r_oh     <= hit ? e_handle[hit_idx] : '0;
          r_ot     <= hit ? e_token[hit_idx][14:0] : '0;
          r_of     <= hit && e_token[hit_idx][15];
          r_op     <= hit ? e_prio[hit_idx] : '0;
        end
        OP_ACK: begin
          r_status <= !r_flag ? ST_ACK_IGN : (hit ? ST_ACK_MATCH : ST_ACK_MISS);
          r_oh     <= (r_flag && hit) ? e_handle[hit_idx] : '0;
          r_ot <= '0; r_of <= 1'b0; r_op <= '0;
        end
        default: begin
          r_status <= ST_OK;
          r_oh <= '0; r_ot <= '0; r_of <= 1'b0; r_op <= '0;
        end
      endcase
    end else if (cmd.scan && stat.last && !stat.found) begin
      r_ev <= (op == OP_PUSH) && (low_ok || e_prio[idx] < low);
    end else if (cmd.load) begin
      r_ev <= 1'b0;
    end
  end

  always_comb begin
    res.status         = r_status;
    res.out_handle     = r_oh;
    res.out_token      = r_ot;
    res.out_token_flag = r_of;
    res.out_priority   = r_op;
    res.evicted        = r_ev && op == OP_PUSH;
    res.used_count     = used_t;
    res.ready_count    = ready_t;
    res.waiting_count  = wait_t;
    res.failed_total   = failed;
  end

endmodule

// File: rtl/core/ack_retry_spool.sv
// ----------------------------------------------------------------------------
// ack_retry_spool
// Retransmission table of ENTRIES slots with ack timeout and retry.
// ----------------------------------------------------------------------------
// Flow: accept, scan, finish, then load the result word into the output
//   register; a new word is taken only once the spool is back in idle.
// The table scan visits one entry per cycle and may stop early on a hit;
//   the next word waits longer while a result waits to be taken.
// Reset (rst, synchronous): every slot free, counters zero, timeout 2500 ms,
//   retry limit 5.
module ack_retry_spool import ars_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // operation[1:0], packet_handle[17:2], priority_req[25:18], token[40:26],
  // token_ack_flag[41], wants_ack[42], elapsed_ms[58:43], zero fill
  input  logic [63:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[2:0], out_handle[18:3], out_token[33:19], out_token_flag[34],
  // out_priority[42:35], evicted[43], used_count[48:44], ready_count[53:49],
  // waiting_count[58:54], failed_total[74:59], zero fill
  output logic [79:0] m_axis_tdata
);

  ars_cmd_t  cmd;
  ars_stat_t stat;
  ars_res_t  res;
  logic      busy, res_load, in_fire, out_free;

  assign s_axis_tready = !busy;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  // output slot is free when empty or being drained this cycle
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  ars_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .out_free(out_free),
    .stat(stat), .cmd(cmd), .busy(busy), .res_load(res_load)
  );

  ars_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd),
    .cfg_we(cfg_we), .cfg_idx(cfg_index), .cfg_data(cfg_data),
    .operation(s_axis_tdata[1:0]), .packet_handle(s_axis_tdata[17:2]),
    .priority_req(s_axis_tdata[25:18]), .token(s_axis_tdata[40:26]),
    .token_ack_flag(s_axis_tdata[41]), .wants_ack(s_axis_tdata[42]),
    .elapsed_ms(s_axis_tdata[58:43]), .stat(stat), .res(res)
  );

  // hold the result word until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) m_axis_tdata <= {5'd0, res};
  end

endmodule

// File: rtl/core/ars_checker.sv
// ----------------------------------------------------------------------------
// ars_checker
// Port-level checks on the spool, bound to the top level.
// ----------------------------------------------------------------------------
module ars_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [79:0] m_axis_tdata
);

  // a held result word does not change
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // no new input taken in the cycle right after one is accepted
  a_one: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second word accepted during scan");

  // status code stays in its legal range
  a_stat: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[2:0] <= 3'd5)
    else $error("bad status");

  // used count equals ready plus waiting
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ({1'b0, m_axis_tdata[53:49]} + {1'b0, m_axis_tdata[58:54]})
      == {1'b0, m_axis_tdata[48:44]})
    else $error("counts inconsistent");

endmodule

bind ack_retry_spool ars_checker u_ars_checker (
  .clk(clk), .rst(rst), .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
